// ----- src/lruc_pkg.sv -----
// Package with the shared widths, defaults and reset values of the LRU cache.
`timescale 1ns / 1ps
`default_nettype none
package lruc_pkg;

    // Width of the key field on the input and result channels.
    localparam int KEY_IN_W = 32;

    // Width of the capacity register.
    localparam int CFG_W = 5;

    // Defaults for the top-level parameters.
    localparam int DEF_ENTRIES  = 16;
    localparam int DEF_KEY_BITS = 32;

    // Capacity after reset.
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

endpackage
`default_nettype wire

// ----- src/lruc_if.sv -----
// Valid/ready channel interfaces for lookup beats and result beats.
`timescale 1ns / 1ps
`default_nettype none

// Lookup channel: one key per beat.
interface lruc_in_if;
    import lruc_pkg::*;

    logic                valid;
    logic                ready;
    logic [KEY_IN_W-1:0] lookup_key;

    modport source (output valid, output lookup_key, input ready);
    modport sink   (input valid, input lookup_key, output ready);
endinterface

// Result channel: hit flag and eviction report per beat.
interface lruc_out_if;
    import lruc_pkg::*;

    logic                valid;
    logic                ready;
    logic                hit;
    logic                evicted;
    logic [KEY_IN_W-1:0] evicted_key;

    modport source (output valid, output hit, output evicted, output evicted_key,
                    input ready);
    modport sink   (input valid, input hit, input evicted, input evicted_key,
                    output ready);
endinterface
`default_nettype wire

// ----- src/lru_cache_lookup_insert.sv -----
// Fully associative LRU key cache with lookup, insert and eviction report.
//
//  Channel   Dir  Handshake          Payload
//  i_in      in   valid / ready      lookup_key
//  o_out     out  valid / ready      hit, evicted, evicted_key
//  i_cfg_*   in   write enable only  capacity_in_use (5 bits)
//
// One lookup beat is taken per cycle while the result channel does not stall; its result
// is offered from the result register, which the pass loads from the input register.
// The single pass compares all entries at once and updates every rank in the
// same cycle, so back-to-back keys always see the state left by the one before.
// Reset clears the valid bits and the entry count and sets the capacity to 16;
// no clearing pass is needed.
// A stalled result holds the input register, and ready drops once it is full.
`timescale 1ns / 1ps
`default_nettype none
module lru_cache_lookup_insert #(
    parameter int ENTRIES  = lruc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS = lruc_pkg::DEF_KEY_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    lruc_in_if.sink                         i_in,
    lruc_out_if.source                      o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [lruc_pkg::CFG_W-1:0] i_cfg_data
);
    import lruc_pkg::*;

    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CP_W   = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;

    // Input stage.
    logic                r_in_valid;
    logic [KEY_BITS-1:0] r_in_key;
    logic [KEY_BITS-1:0] w_key_masked;

    // Cache state.
    logic [KEY_BITS-1:0] r_keys [ENTRIES];
    logic [RANK_W-1:0]   r_rank [ENTRIES];
    logic [RANK_W-1:0]   n_rank [ENTRIES];
    logic [ENTRIES-1:0]  r_valid;
    logic [ENTRIES-1:0]  n_valid;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CFG_W-1:0]    r_cap;

    // Result register.
    logic                r_out_valid;
    logic                r_hit;
    logic                r_evicted;
    logic [KEY_IN_W-1:0] r_ev_key;

    // Lookup logic.
    logic                w_advance;
    logic [ENTRIES-1:0]  w_match;
    logic                w_hit;
    logic [RANK_W-1:0]   w_hit_rank;
    logic [RANK_W-1:0]   w_last_rank;
    logic [ENTRIES-1:0]  w_oldest;
    logic [ENTRIES-1:0]  w_free_sel;
    logic [ENTRIES-1:0]  w_slot;
    logic [CMP_W-1:0]    w_cap_ext;
    logic [CMP_W-1:0]    w_eff_cap;
    logic                w_need_evict;
    logic [KEY_BITS-1:0] w_old_key;
    logic [KEY_IN_W-1:0] w_ev_key;

    function automatic logic [RANK_W-1:0] w_sub_rank(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] dec;
        dec = cnt - CNT_W'(1);
        return dec[RANK_W-1:0];
    endfunction

    // Handshake: the pass runs when the result register is free or being drained.
    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;

    assign o_out.valid       = r_out_valid;
    assign o_out.hit         = r_hit;
    assign o_out.evicted     = r_evicted;
    assign o_out.evicted_key = r_ev_key;

    // Keys are cut or zero-extended to the stored key width.
    always_comb begin
        w_key_masked = '0;
        for (int b = 0; b < CP_W; b++) begin
            w_key_masked[b] = i_in.lookup_key[b];
        end
    end

    // Compare every valid entry against the key and gather the hit rank.
    always_comb begin
        w_hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_keys[i] == r_in_key);
            if (w_match[i]) begin
                w_hit_rank = w_hit_rank | r_rank[i];
            end
        end
        w_hit = |w_match;
    end

    // Effective capacity: zero acts as one, anything above the depth as the depth.
    always_comb begin
        w_cap_ext = CMP_W'(r_cap);
        if (w_cap_ext == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(ENTRIES)) begin
            w_eff_cap = CMP_W'(ENTRIES);
        end else begin
            w_eff_cap = w_cap_ext;
        end
        w_need_evict = (CMP_W'(r_count) >= w_eff_cap);
    end

    // The least recent entry holds the highest rank, which is count minus one.
    assign w_last_rank = w_sub_rank(r_count);

    always_comb begin
        w_old_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_oldest[i] = r_valid[i] && (r_rank[i] == w_last_rank);
            if (w_oldest[i]) begin
                w_old_key = w_old_key | r_keys[i];
            end
        end
    end

    // Lowest-numbered free entry, as a one-hot select.
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_free_sel[i] = !r_valid[i] && !seen;
            if (!r_valid[i]) begin
                seen = 1'b1;
            end
        end
    end

    assign w_slot = w_need_evict ? w_oldest : w_free_sel;

    // Evicted key goes out at the fixed result width.
    always_comb begin
        w_ev_key = '0;
        if (w_need_evict) begin
            for (int b = 0; b < CP_W; b++) begin
                w_ev_key[b] = w_old_key[b];
            end
        end
    end

    // Next valid bits, ranks and count.
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_count = r_count;
        if (w_advance) begin
            if (w_hit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (w_match[i]) begin
                        n_rank[i] = '0;
                    end else if (r_valid[i] && (r_rank[i] < w_hit_rank)) begin
                        n_rank[i] = r_rank[i] + RANK_W'(1);
                    end
                end
            end else begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (w_slot[i]) begin
                        n_valid[i] = 1'b1;
                        n_rank[i]  = '0;
                    end else if (r_valid[i]) begin
                        n_rank[i] = r_rank[i] + RANK_W'(1);
                    end
                end
                if (!w_need_evict) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_valid <= n_valid;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // Payload registers: keys, ranks, input key and result fields.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_key <= w_key_masked;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            r_rank[i] <= n_rank[i];
            if (w_advance && !w_hit && w_slot[i]) begin
                r_keys[i] <= r_in_key;
            end
        end
        if (w_advance) begin
            r_hit     <= w_hit;
            r_evicted <= !w_hit && w_need_evict;
            r_ev_key  <= w_hit ? '0 : w_ev_key;
        end
    end

    // The count always equals the number of valid entries.
    a_count_matches_valid: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count)
    ) else $error("entry count differs from the number of valid entries");

    // A result is never both a hit and an eviction.
    a_hit_no_evict: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_evicted)
    ) else $error("result reports a hit together with an eviction");

    // A hit leaves the set of valid entries unchanged.
    a_hit_keeps_valid: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_hit) |=> $stable(r_valid)
    ) else $error("hit changed the valid entries");

    // An eviction never lets the count grow.
    a_evict_keeps_count: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !w_hit && w_need_evict) |=> $stable(r_count)
    ) else $error("eviction changed the entry count");

endmodule
`default_nettype wire
